/* rtl/wsv_pkg.sv */
// ----------------------------------------------------------------------------
// wsv_pkg
// Shared constants, register codes and the configuration struct of the
// wheel speed voter.
// ----------------------------------------------------------------------------
`default_nettype none

package wsv_pkg;

  // Default width of one wheel speed sample.
  localparam int unsigned SPEED_BITS_DEF = 16;

  localparam int unsigned NUM_WHEELS  = 4;
  localparam int unsigned LIMIT_BITS  = 16;
  localparam int unsigned COUNT_BITS  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  localparam logic [LIMIT_BITS-1:0] AGREE_LIMIT_RST   = 16'd30;
  localparam logic [COUNT_BITS-1:0] WHEELS_IN_USE_RST = 3'd4;
  localparam logic [COUNT_BITS-1:0] MAX_WHEELS        = 3'd4;

  // Exact division by three of a residue below 2**RES_BITS: multiply by
  // ceil(2**DIV3_SHIFT / 3) and shift.
  localparam int unsigned RES_BITS   = LIMIT_BITS + 2;
  localparam int unsigned DIV3_SHIFT = RES_BITS + 1;
  localparam logic [RES_BITS-1:0] DIV3_MUL = RES_BITS'(((2 ** DIV3_SHIFT) + 2) / 3);

  // Register index, taken from paddr[2].
  typedef enum logic [0:0] {
    REG_AGREE_LIMIT   = 1'b0,
    REG_WHEELS_IN_USE = 1'b1
  } wsv_reg_e;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] agree_limit;
    logic [COUNT_BITS-1:0] wheels_in_use;
  } wsv_cfg_t;

endpackage

`default_nettype wire

/* rtl/wsv_if.sv */
// ----------------------------------------------------------------------------
// wsv_if
// Valid/ready channels of the wheel speed voter: the sample set going in and
// the voted speed coming out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsv_in_if #(
  parameter int unsigned SPEED_BITS = wsv_pkg::SPEED_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SPEED_BITS-1:0] wheel_speed_0;
  logic signed [SPEED_BITS-1:0] wheel_speed_1;
  logic signed [SPEED_BITS-1:0] wheel_speed_2;
  logic signed [SPEED_BITS-1:0] wheel_speed_3;
  logic                         wheel_fresh_0;
  logic                         wheel_fresh_1;
  logic                         wheel_fresh_2;
  logic                         wheel_fresh_3;

  modport source (
    output valid, wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3,
    output wheel_fresh_0, wheel_fresh_1, wheel_fresh_2, wheel_fresh_3,
    input  ready
  );
  modport sink (
    input  valid, wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3,
    input  wheel_fresh_0, wheel_fresh_1, wheel_fresh_2, wheel_fresh_3,
    output ready
  );
endinterface

interface wsv_out_if #(
  parameter int unsigned SPEED_BITS = wsv_pkg::SPEED_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic signed [SPEED_BITS-1:0]         vehicle_speed;
  logic [wsv_pkg::COUNT_BITS-1:0]       fresh_count;

  modport source (output valid, vehicle_speed, fresh_count, input ready);
  modport sink   (input valid, vehicle_speed, fresh_count, output ready);
endinterface

`default_nettype wire

/* rtl/wsv_apb_regs.sv */
// ----------------------------------------------------------------------------
// wsv_apb_regs
// APB register file holding the agreement limit and the wheel count.
// ----------------------------------------------------------------------------
`default_nettype none

module wsv_apb_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [wsv_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [wsv_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [wsv_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready,
  output wsv_pkg::wsv_cfg_t                       cfg_o
);

  wsv_pkg::wsv_cfg_t cfg_q;
  wsv_pkg::wsv_cfg_t cfg_d;
  wsv_pkg::wsv_reg_e reg_sel;

  assign reg_sel = wsv_pkg::wsv_reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (reg_sel)
        wsv_pkg::REG_AGREE_LIMIT: begin
          cfg_d.agree_limit = pwdata[wsv_pkg::LIMIT_BITS-1:0];
        end
        wsv_pkg::REG_WHEELS_IN_USE: begin
          cfg_d.wheels_in_use = pwdata[wsv_pkg::COUNT_BITS-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      wsv_pkg::REG_AGREE_LIMIT:   prdata = wsv_pkg::APB_DATA_W'(cfg_q.agree_limit);
      wsv_pkg::REG_WHEELS_IN_USE: prdata = wsv_pkg::APB_DATA_W'(cfg_q.wheels_in_use);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.agree_limit   <= wsv_pkg::AGREE_LIMIT_RST;
      cfg_q.wheels_in_use <= wsv_pkg::WHEELS_IN_USE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/wsv_sort4.sv */
// ----------------------------------------------------------------------------
// wsv_sort4
// Five-exchange sorting network over four samples. Samples that do not take
// part sort above all others, so the n voting samples end up ascending in
// the lowest n places.
// ----------------------------------------------------------------------------
`default_nettype none

module wsv_sort4 #(
  parameter int unsigned SPEED_BITS = wsv_pkg::SPEED_BITS_DEF
) (
  input  wire logic signed [SPEED_BITS-1:0]          speed_i [wsv_pkg::NUM_WHEELS],
  input  wire logic        [wsv_pkg::NUM_WHEELS-1:0] fresh_i,
  input  wire logic        [wsv_pkg::COUNT_BITS-1:0] wheels_in_use_i,
  output logic signed      [SPEED_BITS-1:0]          sorted_o [wsv_pkg::NUM_WHEELS],
  output logic             [wsv_pkg::COUNT_BITS-1:0] count_o
);

  logic [wsv_pkg::COUNT_BITS-1:0] used;
  logic [wsv_pkg::NUM_WHEELS-1:0] take;

  logic signed [SPEED_BITS-1:0] v0 [wsv_pkg::NUM_WHEELS];
  logic signed [SPEED_BITS-1:0] v1 [wsv_pkg::NUM_WHEELS];
  logic signed [SPEED_BITS-1:0] v2 [wsv_pkg::NUM_WHEELS];
  logic [wsv_pkg::NUM_WHEELS-1:0] x0, x1, x2;
  logic sw01, sw23, sw02, sw13, sw12;

  // True when key a (out flag, value) sorts after key b.
  function automatic logic key_gt(input logic xa, input logic signed [SPEED_BITS-1:0] a,
                                  input logic xb, input logic signed [SPEED_BITS-1:0] b);
    key_gt = (xa & ~xb) | ((xa == xb) & (a > b));
  endfunction

  assign used = (wheels_in_use_i > wsv_pkg::MAX_WHEELS) ? wsv_pkg::MAX_WHEELS
                                                         : wheels_in_use_i;

  always_comb begin
    for (int i = 0; i < wsv_pkg::NUM_WHEELS; i++) begin
      take[i] = fresh_i[i] && (wsv_pkg::COUNT_BITS'(i) < used);
    end
  end

  always_comb begin
    count_o = '0;
    for (int i = 0; i < wsv_pkg::NUM_WHEELS; i++) begin
      count_o = count_o + wsv_pkg::COUNT_BITS'(take[i]);
    end
  end

  // First layer: (0,1) and (2,3).
  assign x0   = ~take;
  assign sw01 = key_gt(x0[0], speed_i[0], x0[1], speed_i[1]);
  assign sw23 = key_gt(x0[2], speed_i[2], x0[3], speed_i[3]);
  assign v0[0] = sw01 ? speed_i[1] : speed_i[0];
  assign v0[1] = sw01 ? speed_i[0] : speed_i[1];
  assign v0[2] = sw23 ? speed_i[3] : speed_i[2];
  assign v0[3] = sw23 ? speed_i[2] : speed_i[3];
  assign x1 = {sw23 ? x0[2] : x0[3], sw23 ? x0[3] : x0[2],
               sw01 ? x0[0] : x0[1], sw01 ? x0[1] : x0[0]};

  // Second layer: (0,2) and (1,3).
  assign sw02 = key_gt(x1[0], v0[0], x1[2], v0[2]);
  assign sw13 = key_gt(x1[1], v0[1], x1[3], v0[3]);
  assign v1[0] = sw02 ? v0[2] : v0[0];
  assign v1[2] = sw02 ? v0[0] : v0[2];
  assign v1[1] = sw13 ? v0[3] : v0[1];
  assign v1[3] = sw13 ? v0[1] : v0[3];
  assign x2 = {sw13 ? x1[1] : x1[3], sw02 ? x1[0] : x1[2],
               sw13 ? x1[3] : x1[1], sw02 ? x1[2] : x1[0]};

  // Third layer: (1,2).
  assign sw12 = key_gt(x2[1], v1[1], x2[2], v1[2]);
  assign v2[0] = v1[0];
  assign v2[1] = sw12 ? v1[2] : v1[1];
  assign v2[2] = sw12 ? v1[1] : v1[2];
  assign v2[3] = v1[3];

  assign sorted_o = v2;

endmodule

`default_nettype wire

/* rtl/wsv_vote.sv */
// ----------------------------------------------------------------------------
// wsv_vote
// Vote over the sorted fresh samples: median mean, agreeing triple or pair,
// pair check, single sample or zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wsv_vote #(
  parameter int unsigned SPEED_BITS = wsv_pkg::SPEED_BITS_DEF
) (
  input  wire logic signed [SPEED_BITS-1:0]          sorted_i [wsv_pkg::NUM_WHEELS],
  input  wire logic        [wsv_pkg::COUNT_BITS-1:0] count_i,
  input  wire logic        [wsv_pkg::LIMIT_BITS-1:0] agree_limit_i,
  output logic signed      [SPEED_BITS-1:0]          speed_o
);

  localparam int unsigned CW = (SPEED_BITS > wsv_pkg::LIMIT_BITS) ? SPEED_BITS
                                                                  : wsv_pkg::LIMIT_BITS;
  localparam int unsigned RB = wsv_pkg::RES_BITS;

  logic signed [SPEED_BITS:0]   d10, d21, sum01, sum12, half01, half12;
  logic signed [SPEED_BITS+1:0] sum3;
  logic [CW-1:0]                d10_u, d21_u, lim_u;
  logic                         lo_ok, hi_ok, pair_bad;
  logic [RB-1:0]                res, quo, quo3;
  logic [2*RB-1:0]              prod;
  logic                         round_up;
  logic [SPEED_BITS-1:0]        mean3;
  logic signed [SPEED_BITS-1:0] mean01, mean12;

  assign d10   = (SPEED_BITS+1)'(sorted_i[1]) - (SPEED_BITS+1)'(sorted_i[0]);
  assign d21   = (SPEED_BITS+1)'(sorted_i[2]) - (SPEED_BITS+1)'(sorted_i[1]);
  assign d10_u = CW'(d10[SPEED_BITS-1:0]);
  assign d21_u = CW'(d21[SPEED_BITS-1:0]);
  assign lim_u = CW'(agree_limit_i);

  assign lo_ok    = d10_u < lim_u;
  assign hi_ok    = d21_u < lim_u;
  assign pair_bad = d10_u > lim_u;

  // Means of two round toward minus infinity: arithmetic shift of the sum.
  assign sum01  = (SPEED_BITS+1)'(sorted_i[0]) + (SPEED_BITS+1)'(sorted_i[1]);
  assign sum12  = (SPEED_BITS+1)'(sorted_i[1]) + (SPEED_BITS+1)'(sorted_i[2]);
  assign half01 = sum01 >>> 1;
  assign half12 = sum12 >>> 1;
  assign mean01 = half01[SPEED_BITS-1:0];
  assign mean12 = half12[SPEED_BITS-1:0];

  // The triple mean is a + (2(b-a) + (c-b)) / 3. When both gaps are below
  // the limit the residue stays under 2**RB, so a small reciprocal multiply
  // divides it exactly. Truncation toward zero rounds up for a negative sum
  // with a nonzero remainder.
  assign sum3     = (SPEED_BITS+2)'(sorted_i[0]) + (SPEED_BITS+2)'(sorted_i[1])
                  + (SPEED_BITS+2)'(sorted_i[2]);
  assign res      = (RB'(d10[SPEED_BITS-1:0]) << 1) + RB'(d21[SPEED_BITS-1:0]);
  assign prod     = (2*RB)'(res) * (2*RB)'(wsv_pkg::DIV3_MUL);
  assign quo      = RB'(prod >> wsv_pkg::DIV3_SHIFT);
  assign quo3     = (quo << 1) + quo;
  assign round_up = sum3[SPEED_BITS+1] && (quo3 != res);
  assign mean3    = $unsigned(sorted_i[0]) + SPEED_BITS'(quo) + SPEED_BITS'(round_up);

  always_comb begin
    unique case (count_i)
      3'd4: speed_o = mean12;
      3'd3: begin
        priority if (lo_ok && hi_ok) speed_o = $signed(mean3);
        else if (lo_ok)              speed_o = mean01;
        else if (hi_ok)              speed_o = mean12;
        else                         speed_o = '0;
      end
      3'd2: speed_o = pair_bad ? '0 : mean01;
      3'd1: speed_o = sorted_i[0];
      default: speed_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/wheel_speed_voter.sv */
// Path: an accepted transaction goes to the input register, then the result
// register. Throughput: one transaction per cycle while out_o.ready is high;
// each register takes a new item whenever the stage after it frees up.
// Reset: asynchronous, active low; clears both stage valid flags and loads
// agree_limit = 30 and wheels_in_use = 4. No clearing pass is needed.
// ----------------------------------------------------------------------------
// wheel_speed_voter
// Votes one vehicle speed from four redundant wheel speed samples with
// freshness flags, configured through a small APB register file.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_speed_voter #(
  parameter int unsigned SPEED_BITS = wsv_pkg::SPEED_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  wsv_in_if.sink                              in_i,
  wsv_out_if.source                           out_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wsv_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [wsv_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [wsv_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  // Configuration. Writes must only happen while the pipeline is empty; the
  // block does not enforce this. The vote logic reads the registers directly.
  wsv_pkg::wsv_cfg_t cfg;

  wsv_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage one: input register. It holds one sample set and loads a new one
  // in the same cycle its current content moves on to the result register.
  logic                         s1_valid_q;
  logic signed [SPEED_BITS-1:0] s1_speed_q [wsv_pkg::NUM_WHEELS];
  logic [wsv_pkg::NUM_WHEELS-1:0] s1_fresh_q;

  // Stage two: result register, which drives the output channel directly.
  logic                           s2_valid_q;
  logic signed [SPEED_BITS-1:0]   s2_speed_q;
  logic [wsv_pkg::COUNT_BITS-1:0] s2_count_q;

  logic s2_ready, s1_ready, in_take, s1_move;

  // Ready flows backward: a stage can load when it is empty or when its
  // content leaves in the same cycle.
  assign s2_ready  = !s2_valid_q || out_o.ready;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;
  assign in_take   = in_i.valid && s1_ready;
  assign s1_move   = s1_valid_q && s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_speed_q[0] <= in_i.wheel_speed_0;
      s1_speed_q[1] <= in_i.wheel_speed_1;
      s1_speed_q[2] <= in_i.wheel_speed_2;
      s1_speed_q[3] <= in_i.wheel_speed_3;
      s1_fresh_q    <= {in_i.wheel_fresh_3, in_i.wheel_fresh_2,
                        in_i.wheel_fresh_1, in_i.wheel_fresh_0};
    end
  end

  // Vote logic between the two registers: sort with stale or unused wheels
  // pushed to the top, then pick the voting rule by the fresh count.
  logic signed [SPEED_BITS-1:0]   sorted [wsv_pkg::NUM_WHEELS];
  logic [wsv_pkg::COUNT_BITS-1:0] count;
  logic signed [SPEED_BITS-1:0]   speed;

  wsv_sort4 #(
    .SPEED_BITS (SPEED_BITS)
  ) u_sort (
    .speed_i         (s1_speed_q),
    .fresh_i         (s1_fresh_q),
    .wheels_in_use_i (cfg.wheels_in_use),
    .sorted_o        (sorted),
    .count_o         (count)
  );

  wsv_vote #(
    .SPEED_BITS (SPEED_BITS)
  ) u_vote (
    .sorted_i      (sorted),
    .count_i       (count),
    .agree_limit_i (cfg.agree_limit),
    .speed_o       (speed)
  );

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_speed_q <= speed;
      s2_count_q <= count;
    end
  end

  assign out_o.valid         = s2_valid_q;
  assign out_o.vehicle_speed = s2_speed_q;
  assign out_o.fresh_count   = s2_count_q;

  // A vote with no fresh sample always reports zero speed.
  a_zero_count_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && (s2_count_q == '0)) |-> (s2_speed_q == '0))
    else $error("vote with no fresh sample gave a nonzero speed");

  // The fresh count never exceeds the configured number of wheels.
  a_count_within_wheels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_count_q <= cfg.wheels_in_use))
    else $error("fresh count exceeds wheels in use");

  // A blocked input-stage item stays put until the result register frees.
  a_stage1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(s1_fresh_q)))
    else $error("input stage lost a blocked transaction");

  // An item leaving the input stage always lands in the result register.
  a_stage1_to_stage2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> s2_valid_q)
    else $error("transaction dropped between stages");

  // An accepted transaction is held in the input stage on the next cycle.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted transaction not captured");

endmodule

`default_nettype wire

/* test/tb_wheel_speed_voter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wheel_speed_voter
// Self-checking bench for the wheel speed voter. Sample sets are driven
// through the input channel with random gaps. Every accepted set is voted
// by a local predictor under the current register settings, and each
// output transaction is checked in order against the oldest predicted vote.
// ----------------------------------------------------------------------------

module tb_wheel_speed_voter;

  import wsv_pkg::*;

  localparam int unsigned SPEED_BITS = SPEED_BITS_DEF;

  // The longest run of cycles without any transaction on either channel
  // that a healthy run can show. The longest output stall is well below it.
  localparam int unsigned IDLE_LIMIT = 4000;

  // One set of wheel samples as it enters the block. Bit i of fresh belongs
  // to wheel i.
  typedef struct packed {
    logic [NUM_WHEELS-1:0]                 fresh;
    logic [NUM_WHEELS-1:0][SPEED_BITS-1:0] speed;
  } wheel_set_t;

  // One voted result as it leaves the block.
  typedef struct packed {
    logic [SPEED_BITS-1:0] speed;
    logic [COUNT_BITS-1:0] count;
  } vote_t;

  logic clk;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  wsv_in_if  #(.SPEED_BITS(SPEED_BITS)) in_bus  ();
  wsv_out_if #(.SPEED_BITS(SPEED_BITS)) out_bus ();

  wheel_speed_voter #(.SPEED_BITS(SPEED_BITS)) uut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Local copy of the two registers, updated at the clock edge that writes
  // them in the block.
  logic [LIMIT_BITS-1:0] agree_limit_q;
  logic [COUNT_BITS-1:0] wheels_in_use_q;

  // Votes predicted for accepted sample sets, oldest first.
  vote_t pending_votes[$];
  int    mismatch_count;

  // While steady is high neither side inserts gaps.
  logic steady;

  // Output stall requests. The test raises stall_id; the ready process sees
  // the change and holds ready low while stall_left counts down from stall_len.
  int unsigned stall_len;
  int unsigned stall_id;
  int unsigned stall_seen;
  int unsigned stall_left;

  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Mean of two samples, rounded toward minus infinity. The arithmetic shift
  // of a signed int does exactly that.
  function automatic int half_floor(int sum);
    return sum >>> 1;
  endfunction

  // Votes one speed from a sample set under the current register copies.
  // Only the leading wheels in use count, and of those only the fresh ones.
  // A count above four behaves as four.
  function automatic vote_t vote_speed(wheel_set_t s);
    int    v[NUM_WHEELS];
    int    n;
    int    used;
    int    lim;
    int    spd;
    int    hold;
    int    j;
    bit    lo_ok;
    bit    hi_ok;
    vote_t res;
    used = (wheels_in_use_q > MAX_WHEELS) ? NUM_WHEELS : int'(wheels_in_use_q);
    lim  = int'(agree_limit_q);
    n    = 0;
    for (int i = 0; i < used; i++) begin
      if (s.fresh[i]) begin
        v[n] = int'($signed(s.speed[i]));
        n++;
      end
    end
    // Plain insertion sort; the vote only depends on the sorted values.
    for (int i = 1; i < n; i++) begin
      hold = v[i];
      j    = i - 1;
      while (j >= 0 && v[j] > hold) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = hold;
    end
    case (n)
      4: spd = half_floor(v[1] + v[2]);
      3: begin
        // Three samples need a difference strictly below the limit.
        lo_ok = (v[1] - v[0]) < lim;
        hi_ok = (v[2] - v[1]) < lim;
        if (lo_ok && hi_ok) begin
          spd = (v[0] + v[1] + v[2]) / 3;
        end else if (lo_ok) begin
          spd = half_floor(v[0] + v[1]);
        end else if (hi_ok) begin
          spd = half_floor(v[1] + v[2]);
        end else begin
          spd = 0;
        end
      end
      // Two samples still agree when they differ by exactly the limit.
      2: spd = ((v[1] - v[0]) > lim) ? 0 : half_floor(v[0] + v[1]);
      1: spd = v[0];
      default: spd = 0;
    endcase
    res.speed = SPEED_BITS'(spd);
    res.count = COUNT_BITS'(n);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: ready generation, checking and the watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_seen != stall_id) begin
      stall_seen    <= stall_id;
      stall_left    <= stall_len;
      out_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= steady || ($urandom_range(0, 99) >= 9);
    end
  end

  task automatic report_mismatch(string what, int want, int got);
    $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // Every output transaction is compared with the oldest predicted vote.
  always @(posedge clk) begin : check_votes
    vote_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_votes.size() == 0) begin
        report_mismatch("unexpected vote, speed", 0, int'($signed(out_bus.vehicle_speed)));
      end else begin
        want = pending_votes.pop_front();
        if (out_bus.vehicle_speed !== want.speed) begin
          report_mismatch("vehicle_speed", int'($signed(want.speed)),
                          int'($signed(out_bus.vehicle_speed)));
        end
        if (out_bus.fresh_count !== want.count) begin
          report_mismatch("fresh_count", int'(want.count), int'(out_bus.fresh_count));
        end
      end
    end
  end

  // The run is declared hung when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Input side and register access
  // --------------------------------------------------------------------------

  // Offers one sample set, possibly after a few idle cycles, and predicts its
  // vote at the edge that accepts it. Valid stays high afterwards so that
  // back-to-back sets follow without valid dropping in between.
  task automatic send_wheel_set(wheel_set_t s);
    while (!steady && $urandom_range(0, 99) < 9) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.wheel_speed_0 <= s.speed[0];
    in_bus.wheel_speed_1 <= s.speed[1];
    in_bus.wheel_speed_2 <= s.speed[2];
    in_bus.wheel_speed_3 <= s.speed[3];
    in_bus.wheel_fresh_0 <= s.fresh[0];
    in_bus.wheel_fresh_1 <= s.fresh[1];
    in_bus.wheel_fresh_2 <= s.fresh[2];
    in_bus.wheel_fresh_3 <= s.fresh[3];
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pending_votes.push_back(vote_speed(s));
  endtask

  function automatic wheel_set_t pack_wheels(int s0, int s1, int s2, int s3,
                                             logic [NUM_WHEELS-1:0] fresh);
    wheel_set_t s;
    s.fresh    = fresh;
    s.speed[0] = SPEED_BITS'(s0);
    s.speed[1] = SPEED_BITS'(s1);
    s.speed[2] = SPEED_BITS'(s2);
    s.speed[3] = SPEED_BITS'(s3);
    return s;
  endfunction

  // Stops offering input and waits until every predicted vote has arrived
  // and the pipeline has settled.
  task automatic drain_votes();
    in_bus.valid <= 1'b0;
    while (pending_votes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One APB write: setup cycle, access cycle, then the bus returns to idle.
  task automatic write_reg(wsv_reg_e idx, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // The register took the value at this edge.
    if (idx == REG_AGREE_LIMIT) begin
      agree_limit_q = data[LIMIT_BITS-1:0];
    end else begin
      wheels_in_use_q = data[COUNT_BITS-1:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only while the block is empty.
  task automatic configure(logic [APB_DATA_W-1:0] limit_word,
                           logic [APB_DATA_W-1:0] wheels_word);
    drain_votes();
    write_reg(REG_AGREE_LIMIT, limit_word);
    write_reg(REG_WHEELS_IN_USE, wheels_word);
  endtask

  // Draws a sample set. Most sets lie within the agreement limit plus two of
  // a base speed, so that every branch of the vote is reached; the rest are
  // fully random or built from the corner values.
  function automatic wheel_set_t draw_wheel_set();
    wheel_set_t s;
    int         mode;
    int         base;
    int         spread;
    int         val;
    mode    = $urandom_range(0, 9);
    base    = int'($urandom_range(0, 65535)) - 32768;
    spread  = int'(agree_limit_q) + 2;
    s.fresh = NUM_WHEELS'($urandom_range(0, 15));
    for (int i = 0; i < NUM_WHEELS; i++) begin
      case (mode)
        0, 1, 2, 3, 4, 5: begin
          val = base + int'($urandom_range(0, 2 * spread)) - spread;
          if (val > 32767) val = 32767;
          if (val < -32768) val = -32768;
        end
        6, 7: val = int'($urandom_range(0, 65535)) - 32768;
        default: begin
          case ($urandom_range(0, 3))
            0: val = -32768;
            1: val = 32767;
            2: val = 0;
            default: val = -1;
          endcase
        end
      endcase
      s.speed[i] = SPEED_BITS'(val);
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // All four fresh: mean of the middle two, including both range ends and a
  // negative odd sum that must round down.
  task automatic test_four_fresh();
    send_wheel_set(pack_wheels(32767, 32767, 32767, 32767, 4'b1111));
    send_wheel_set(pack_wheels(-32768, -32768, -32768, -32768, 4'b1111));
    send_wheel_set(pack_wheels(-32768, 32767, -32768, 32767, 4'b1111));
    send_wheel_set(pack_wheels(5, -3, 100, 2, 4'b1111));
  endtask

  // Three fresh under the reset limit of 30: agreeing triple, triple whose
  // negative sum truncates toward zero, lower pair only with a gap of exactly
  // the limit above it, upper pair only, and no agreement at all.
  task automatic test_three_fresh();
    send_wheel_set(pack_wheels(10, 20, 30, 999, 4'b0111));
    send_wheel_set(pack_wheels(-1, -1, 777, 0, 4'b1011));
    send_wheel_set(pack_wheels(-5, -4, -4, -4, 4'b1110));
    send_wheel_set(pack_wheels(59, 0, 29, 5, 4'b0111));
    send_wheel_set(pack_wheels(-40, 3, -10, -1, 4'b1101));
    send_wheel_set(pack_wheels(200, 100, 0, 50, 4'b0111));
  endtask

  // Two fresh: a difference equal to the limit still agrees, one more does
  // not, and an odd negative sum rounds down.
  task automatic test_two_fresh();
    send_wheel_set(pack_wheels(0, 1, 30, 2, 4'b0101));
    send_wheel_set(pack_wheels(4, 0, 9, 31, 4'b1010));
    send_wheel_set(pack_wheels(-3, 0, 8, 8, 4'b0011));
  endtask

  // A single fresh sample passes through; no fresh sample gives zero.
  task automatic test_single_and_none();
    send_wheel_set(pack_wheels(1, 2, 3, -32768, 4'b1000));
    send_wheel_set(pack_wheels(32767, -32768, 123, -7, 4'b0000));
  endtask

  // The widest limit lets opposite range ends agree; a zero limit keeps
  // equal pairs agreeing but rejects every triple.
  task automatic test_limit_extremes();
    configure(32'd65535, 32'd4);
    send_wheel_set(pack_wheels(-32768, 32767, 0, 0, 4'b0011));
    send_wheel_set(pack_wheels(-32768, 0, 32767, 1, 4'b0111));
    configure(32'd0, 32'd4);
    send_wheel_set(pack_wheels(7, 7, 0, 0, 4'b0011));
    send_wheel_set(pack_wheels(7, 8, 0, 0, 4'b0011));
    send_wheel_set(pack_wheels(5, 5, 5, 0, 4'b0111));
  endtask

  // Only the leading wheels vote; counts above four act as four.
  task automatic test_wheel_count();
    configure(32'd30, 32'd0);
    send_wheel_set(pack_wheels(10, 20, 30, 40, 4'b1111));
    configure(32'd30, 32'd2);
    send_wheel_set(pack_wheels(10, 20, 30000, -30000, 4'b1111));
    configure(32'd30, 32'd5);
    send_wheel_set(pack_wheels(10, 20, 30, 40, 4'b1111));
    configure(32'd30, 32'd7);
    send_wheel_set(pack_wheels(-9, 20, 30, 40, 4'b1101));
    configure(32'd30, 32'd3);
    send_wheel_set(pack_wheels(1, 2, 3, 4, 4'b1111));
  endtask

  // Five phases of random sets, each under its own register settings. The
  // register words carry random upper bits that the block must ignore. The
  // third phase runs without gaps on either side.
  task automatic test_random_votes();
    logic [APB_DATA_W-1:0] limit_word;
    logic [APB_DATA_W-1:0] wheels_word;
    int                    pick;
    for (int phase = 0; phase < 5; phase++) begin
      limit_word  = $urandom;
      wheels_word = $urandom;
      case ($urandom_range(0, 5))
        0: limit_word[LIMIT_BITS-1:0] = '0;
        1: limit_word[LIMIT_BITS-1:0] = '1;
        2: limit_word[LIMIT_BITS-1:0] = LIMIT_BITS'($urandom_range(1, 64));
        3: limit_word[LIMIT_BITS-1:0] = LIMIT_BITS'($urandom_range(0, 65535));
        default: limit_word[LIMIT_BITS-1:0] = LIMIT_BITS'($urandom_range(10, 400));
      endcase
      // Four wheels most of the time, since that reaches every vote size.
      pick = $urandom_range(0, 11);
      wheels_word[COUNT_BITS-1:0] = (pick > 7) ? MAX_WHEELS : COUNT_BITS'(pick);
      if (phase == 0) wheels_word[COUNT_BITS-1:0] = MAX_WHEELS;
      configure(limit_word, wheels_word);
      steady <= (phase == 2);
      for (int k = 0; k < 80; k++) begin
        send_wheel_set(draw_wheel_set());
      end
    end
    drain_votes();
    steady <= 1'b0;
  endtask

  // The receiver holds off for a long stretch while sets keep coming, so the
  // pipeline fills and the input stalls.
  task automatic test_output_stall();
    configure(32'd30, 32'd4);
    stall_len = 80;
    stall_id <= stall_id + 1;
    for (int k = 0; k < 40; k++) begin
      send_wheel_set(draw_wheel_set());
    end
  endtask

  // The sender pauses until every vote is out, then starts again.
  task automatic test_sender_drain();
    for (int k = 0; k < 15; k++) begin
      send_wheel_set(draw_wheel_set());
    end
    drain_votes();
    for (int k = 0; k < 15; k++) begin
      send_wheel_set(draw_wheel_set());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    // Every stimulus input is known from the first moment, and ready follows
    // from the first clock edge; reset loads the register defaults, which the
    // local copy mirrors.
    rst_ni               <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_bus.valid         <= 1'b0;
    in_bus.wheel_speed_0 <= '0;
    in_bus.wheel_speed_1 <= '0;
    in_bus.wheel_speed_2 <= '0;
    in_bus.wheel_speed_3 <= '0;
    in_bus.wheel_fresh_0 <= 1'b0;
    in_bus.wheel_fresh_1 <= 1'b0;
    in_bus.wheel_fresh_2 <= 1'b0;
    in_bus.wheel_fresh_3 <= 1'b0;
    steady               <= 1'b0;
    stall_id             <= 0;
    stall_len            = 0;
    mismatch_count       = 0;
    agree_limit_q        = AGREE_LIMIT_RST;
    wheels_in_use_q      = WHEELS_IN_USE_RST;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // The directed tests start under the reset settings.
    test_four_fresh();
    test_three_fresh();
    test_two_fresh();
    test_single_and_none();
    test_limit_extremes();
    test_wheel_count();
    test_random_votes();
    test_output_stall();
    test_sender_drain();

    drain_votes();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_votes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/wsv_pkg.sv
rtl/wsv_if.sv
rtl/wsv_apb_regs.sv
rtl/wsv_sort4.sv
rtl/wsv_vote.sv
rtl/wheel_speed_voter.sv
test/tb_wheel_speed_voter.sv
